// File: rtl/bts_pkg.sv
`default_nettype none

package bts_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int MAX_RUNS_DEF    = 64;
    localparam int QUEUE_DEPTH     = 4;

    localparam int LEVEL_W     = 16;
    localparam int SUM_W       = 18;
    localparam int LUMA_W      = 8;
    localparam int PROD_W      = 36;
    localparam int LUMA_LSB    = 27;
    localparam logic [SUM_W-1:0] RECIP3 = 18'd174763;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_DATA_W-1:0] MIN_TAKE_RST = 13'd64;
    localparam logic [CFG_DATA_W-1:0] MIN_ELEM_RST = 13'd2;

    localparam logic [LUMA_W-1:0] FLAT_RANGE = 8'd16;
    localparam logic [LUMA_W-1:0] LUMA_MAX   = 8'd255;

    localparam int RUN_START_W = 12;
    localparam int RUN_WIDTH_W = 13;
    localparam int RUN_COUNT_W = 7;
    localparam int MEAN_W      = 13;
    localparam int TAKE_LEN_W  = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_TAKE = 2'd0,
        REG_MIN_ELEM = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_FLAT  = 2'd2,
        STAT_FEW   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_REC,
        ST_CHECK,
        ST_FIRST,
        ST_WALK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT_WR,
        ST_REJECT
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic               end_of_take;
    } in_word_t;

    typedef struct packed {
        status_t                status;
        logic [RUN_START_W-1:0] run_start;
        logic [RUN_WIDTH_W-1:0] run_width;
        logic                   run_dark;
        logic [RUN_COUNT_W-1:0] run_count;
        logic [MEAN_W-1:0]      mean_width;
        logic [TAKE_LEN_W-1:0]  take_length;
        logic                   last;
    } out_word_t;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic              end_of_take;
    } smp_t;

endpackage

`default_nettype wire

// File: rtl/bts_front.sv
`default_nettype none

module bts_front import bts_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output smp_t          q_word
);

    logic             vld_reg;
    logic [SUM_W-1:0] sum_reg;
    logic             end_reg;
    logic [PROD_W-1:0] prod;

    assign s_ready = !vld_reg || q_ready;
    assign q_valid = vld_reg;
    assign prod    = PROD_W'(sum_reg) * PROD_W'(RECIP3);

    always_comb begin
        q_word.luma        = prod[LUMA_LSB +: LUMA_W];
        q_word.end_of_take = end_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (q_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sum_reg <= SUM_W'(s_data.red_level) + SUM_W'(s_data.green_level)
                       + SUM_W'(s_data.blue_level);
            end_reg <= s_data.end_of_take;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bts_queue.sv
`default_nettype none

module bts_queue import bts_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire smp_t in_word,
    output logic      out_valid,
    input  wire logic out_ready,
    output smp_t      out_word
);

    localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    smp_t           slot_reg [DEPTH];
    logic [PW-1:0]  wr_reg;
    logic [PW-1:0]  rd_reg;
    logic [CNW-1:0] cnt_reg;
    logic           push;
    logic           pop;

    assign in_ready  = (cnt_reg != CNW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_word  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= in_word;
        end
    end

endmodule

`default_nettype wire

// File: rtl/bts_divider.sv
`default_nettype none

module bts_divider #(
    parameter int DW = 13,
    parameter int VW = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int SW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] div_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   shifted;
    logic          fits;

    assign shifted  = {rem_reg, quo_reg[DW-1]};
    assign fits     = (shifted >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (step_reg == SW'(1));
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (step_reg == SW'(1))) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            step_reg <= SW'(DW);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (fits) begin
                rem_reg <= VW'(shifted - {1'b0, div_reg});
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/bts_back.sv
`default_nettype none

module bts_back import bts_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int MAX_RUNS    = MAX_RUNS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    output logic                       q_ready,
    input  wire smp_t                  q_word,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int NW   = $clog2(MAX_RUNS + 1);
    localparam int RW   = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int WW   = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
    localparam int RUNW = AW + CW + 1;

    logic [LUMA_W-1:0] smp_mem [MAX_SAMPLES];
    logic [RUNW-1:0]   run_mem [MAX_RUNS];

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg;
    logic [LUMA_W-1:0] min_reg, max_reg;
    logic [LUMA_W-1:0] mid_reg, lo_reg, hi_reg;
    logic [CW-1:0]     cur_reg;
    logic [AW-1:0]     seg_reg;
    logic              dark_reg;
    logic [NW-1:0]     runs_reg;
    logic [RW-1:0]     emit_reg;
    status_t           rej_reg;
    logic [CW-1:0]     mean_reg;
    logic [CFG_DATA_W-1:0] min_take_reg, min_elem_reg;
    logic              out_vld_reg;
    out_word_t         out_reg;
    logic [LUMA_W-1:0] smp_rdata_reg;
    logic [RUNW-1:0]   run_rdata_reg;

    logic              out_free;
    logic              pop;
    logic              room;
    logic [LUMA_W-1:0] rng;
    logic [LUMA_W:0]   mid_sum;
    logic [LUMA_W-1:0] mid_c, eighth;
    logic [AW-1:0]     smp_ra;
    logic [CW-1:0]     seg_len;
    logic              flip, wide;
    logic              run_we;
    logic [RUNW-1:0]   run_wd;
    logic              div_start, div_done;
    logic [CW-1:0]     div_quo;
    logic              emit_last;
    logic [AW-1:0]     rs_start;
    logic [CW-1:0]     rs_width;
    logic              rs_dark;

    assign out_free  = !out_vld_reg || m_ready;
    assign q_ready   = (state_reg == ST_REC);
    assign pop       = q_valid && q_ready;
    assign room      = (cnt_reg < CW'(MAX_SAMPLES));
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    assign rng     = max_reg - min_reg;
    assign mid_sum = {1'b0, min_reg} + {1'b0, max_reg};
    assign mid_c   = mid_sum[LUMA_W:1];
    assign eighth  = rng >> 3;

    assign seg_len = cur_reg - CW'(seg_reg);
    assign flip    = dark_reg ? (smp_rdata_reg > hi_reg) : (smp_rdata_reg < lo_reg);
    assign wide    = (WW'(seg_len) >= WW'(min_elem_reg));
    assign emit_last = ((NW'(emit_reg) + 1'b1) == runs_reg);
    assign {rs_start, rs_width, rs_dark} = run_rdata_reg;

    bts_divider #(
        .DW(CW),
        .VW(NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (cnt_reg),
        .divisor  (runs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        smp_ra     = '0;
        run_we     = 1'b0;
        run_wd     = '0;
        div_start  = 1'b0;
        case (state_reg)
            ST_REC: begin
                if (pop && q_word.end_of_take) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (WW'(cnt_reg) < WW'(min_take_reg)) begin
                    state_next = ST_REJECT;
                end else if (max_reg < min_reg || rng < FLAT_RANGE) begin
                    state_next = ST_REJECT;
                end else begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                smp_ra     = AW'(1);
                state_next = ST_WALK;
            end
            ST_WALK: begin
                smp_ra = AW'(cur_reg + 1'b1);
                if (cur_reg == cnt_reg) begin
                    run_wd = {seg_reg, CW'(cnt_reg - CW'(seg_reg)), dark_reg};
                    run_we = (runs_reg < NW'(MAX_RUNS)) && (cnt_reg > CW'(seg_reg));
                    state_next = ST_DIV_GO;
                end else begin
                    run_wd = {seg_reg, seg_len, dark_reg};
                    run_we = flip && wide && (runs_reg < NW'(MAX_RUNS));
                end
            end
            ST_DIV_GO: begin
                if (runs_reg < NW'(2)) begin
                    state_next = ST_REJECT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (out_free) begin
                    state_next = emit_last ? ST_REC : ST_EMIT_RD;
                end
            end
            ST_REJECT: begin
                if (out_free) begin
                    state_next = ST_REC;
                end
            end
            default: begin
                state_next = ST_REC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_REC;
        end else begin
            state_reg <= state_next;
        end
    end

    // take bookkeeping and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            min_reg      <= LUMA_MAX;
            max_reg      <= '0;
            min_take_reg <= MIN_TAKE_RST;
            min_elem_reg <= MIN_ELEM_RST;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MIN_TAKE: min_take_reg <= cfg_data;
                    REG_MIN_ELEM: min_elem_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (pop && room) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (q_word.luma < min_reg) begin
                    min_reg <= q_word.luma;
                end
                if (q_word.luma > max_reg) begin
                    max_reg <= q_word.luma;
                end
            end
            if ((state_reg == ST_REJECT || (state_reg == ST_EMIT_WR && emit_last))
                && out_free) begin
                cnt_reg <= '0;
                min_reg <= LUMA_MAX;
                max_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && room) begin
            smp_mem[cnt_reg[AW-1:0]] <= q_word.luma;
        end
        smp_rdata_reg <= smp_mem[smp_ra];
    end

    always_ff @(posedge aclk) begin
        if (run_we) begin
            run_mem[runs_reg[RW-1:0]] <= run_wd;
        end
        run_rdata_reg <= run_mem[emit_reg];
    end

    // walk, division and emit state
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_REC: begin
                runs_reg <= '0;
            end
            ST_CHECK: begin
                mid_reg <= mid_c;
                lo_reg  <= mid_c - eighth;
                hi_reg  <= mid_c + eighth;
                if (WW'(cnt_reg) < WW'(min_take_reg)) begin
                    rej_reg <= STAT_SHORT;
                end else begin
                    rej_reg <= STAT_FLAT;
                end
            end
            ST_FIRST: begin
                dark_reg <= (smp_rdata_reg < mid_reg);
                seg_reg  <= '0;
                cur_reg  <= CW'(1);
            end
            ST_WALK: begin
                if (run_we) begin
                    runs_reg <= runs_reg + 1'b1;
                end
                if (cur_reg != cnt_reg) begin
                    cur_reg <= cur_reg + 1'b1;
                    if (flip && wide) begin
                        seg_reg  <= cur_reg[AW-1:0];
                        dark_reg <= !dark_reg;
                    end
                end
            end
            ST_DIV_GO: begin
                rej_reg <= STAT_FEW;
            end
            ST_DIV_WAIT: begin
                mean_reg <= (div_quo == '0) ? CW'(1) : div_quo;
                emit_reg <= '0;
            end
            ST_EMIT_WR: begin
                if (out_free && !emit_last) begin
                    emit_reg <= emit_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free && (state_reg == ST_REJECT || state_reg == ST_EMIT_WR)) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && state_reg == ST_REJECT) begin
            out_reg.status      <= rej_reg;
            out_reg.run_start   <= '0;
            out_reg.run_width   <= '0;
            out_reg.run_dark    <= 1'b0;
            out_reg.run_count   <= (rej_reg == STAT_FEW) ? RUN_COUNT_W'(runs_reg) : '0;
            out_reg.mean_width  <= '0;
            out_reg.take_length <= TAKE_LEN_W'(cnt_reg);
            out_reg.last        <= 1'b1;
        end else if (out_free && state_reg == ST_EMIT_WR) begin
            out_reg.status      <= STAT_OK;
            out_reg.run_start   <= RUN_START_W'(rs_start);
            out_reg.run_width   <= RUN_WIDTH_W'(rs_width);
            out_reg.run_dark    <= rs_dark;
            out_reg.run_count   <= RUN_COUNT_W'(runs_reg);
            out_reg.mean_width  <= MEAN_W'(mean_reg);
            out_reg.take_length <= TAKE_LEN_W'(cnt_reg);
            out_reg.last        <= emit_last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/barcode_take_segmenter.sv
`default_nettype none

// Barcode take segmenter: colour frames enter one a cycle, while the queue has room,
// through a luma stage and a four-word queue; the back end records one frame per
// cycle into the sample memory. On the frame that ends a take the back end stops
// draining the queue, walks the stored samples at one per cycle, divides the take
// length by the run count in a bit-serial divider as wide as the sample count, then
// sends each run, read from the run memory, through an output register. A rejected
// take gives a single word. Input stalls only once the queue fills during that
// analysis. No clearing pass is needed after reset.
module barcode_take_segmenter import bts_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int MAX_RUNS    = MAX_RUNS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic f_valid, f_ready;
    smp_t f_word;
    logic b_valid, b_ready;
    smp_t b_word;

    bts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_word  (f_word)
    );

    bts_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_word   (f_word),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_word  (b_word)
    );

    bts_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_RUNS    (MAX_RUNS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_word    (b_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// File: tb/barcode_take_segmenter_test.sv
module barcode_take_segmenter_test;
    import bts_pkg::*;

    class run_tracker;
        logic [LUMA_W-1:0] samples [MAX_SAMPLES_DEF];
        int held;
        int lowest;
        int highest;
        int min_take;
        int min_elem;
        out_word_t pending_runs [$];
        int runs_predicted;
        int failures;

        function new();
            clear_take();
            min_take = MIN_TAKE_RST;
            min_elem = MIN_ELEM_RST;
            runs_predicted = 0;
            failures = 0;
        endfunction

        function void clear_take();
            held = 0;
            lowest = LUMA_MAX;
            highest = 0;
        endfunction

        function void set_register(cfg_reg_t idx, int value);
            case (idx)
                REG_MIN_TAKE: min_take = value;
                REG_MIN_ELEM: min_elem = value;
                default: ;
            endcase
        endfunction

        function void push_result(status_t st, int start, int width, bit dark, int count,
                                  int mean, int len, bit last_flag);
            out_word_t w;
            w.status      = st;
            w.run_start   = RUN_START_W'(start);
            w.run_width   = RUN_WIDTH_W'(width);
            w.run_dark    = dark;
            w.run_count   = RUN_COUNT_W'(count);
            w.mean_width  = MEAN_W'(mean);
            w.take_length = TAKE_LEN_W'(len);
            w.last        = last_flag;
            pending_runs.push_back(w);
            runs_predicted++;
        endfunction

        function void segment_take();
            int len;
            int range;
            int mid;
            int lo;
            int hi;
            int seg_start;
            int count;
            int mean;
            int v;
            bit dark;
            bit flip;
            int starts [MAX_RUNS_DEF];
            int widths [MAX_RUNS_DEF];
            bit darks [MAX_RUNS_DEF];
            len = held;
            if (len < min_take) begin
                push_result(STAT_SHORT, 0, 0, 1'b0, 0, 0, len, 1'b1);
                return;
            end
            range = highest - lowest;
            if (highest < lowest || range < int'(FLAT_RANGE)) begin
                push_result(STAT_FLAT, 0, 0, 1'b0, 0, 0, len, 1'b1);
                return;
            end
            mid = (lowest + highest) / 2;
            lo = mid - range / 8;
            hi = mid + range / 8;
            dark = int'(samples[0]) < mid;
            seg_start = 0;
            count = 0;
            for (int cur = 1; cur < len; cur++) begin
                v = samples[cur];
                flip = dark ? (v > hi) : (v < lo);
                if (flip && cur - seg_start >= min_elem) begin
                    if (count < MAX_RUNS_DEF) begin
                        starts[count] = seg_start;
                        widths[count] = cur - seg_start;
                        darks[count] = dark;
                        count++;
                    end
                    seg_start = cur;
                    dark = !dark;
                end
            end
            if (count < MAX_RUNS_DEF && len > seg_start) begin
                starts[count] = seg_start;
                widths[count] = len - seg_start;
                darks[count] = dark;
                count++;
            end
            if (count < 2) begin
                push_result(STAT_FEW, 0, 0, 1'b0, count, 0, len, 1'b1);
                return;
            end
            mean = len / count;
            if (mean == 0)
                mean = 1;
            for (int k = 0; k < count; k++)
                push_result(STAT_OK, starts[k], widths[k], darks[k], count, mean, len,
                            k + 1 == count);
        endfunction

        function void record_frame(in_word_t w);
            int luma;
            luma = ((int'(w.red_level) + int'(w.green_level) + int'(w.blue_level)) / 3) >> 8;
            if (held < MAX_SAMPLES_DEF) begin
                samples[held] = LUMA_W'(luma);
                held++;
                if (luma < lowest)
                    lowest = luma;
                if (luma > highest)
                    highest = luma;
            end
            if (w.end_of_take) begin
                segment_take();
                clear_take();
            end
        endfunction

        function string describe(out_word_t w);
            return {$sformatf("status=%0d start=%0d width=%0d dark=%0d ",
                              w.status, w.run_start, w.run_width, w.run_dark),
                    $sformatf("count=%0d mean=%0d len=%0d last=%0d",
                              w.run_count, w.mean_width, w.take_length, w.last)};
        endfunction

        function void note_failure(string what);
            failures++;
            if (failures <= 10)
                $display("%s", what);
        endfunction

        function void check_run(out_word_t got);
            out_word_t want;
            if (pending_runs.size() == 0) begin
                note_failure({"unexpected run word: ", describe(got)});
                return;
            end
            want = pending_runs.pop_front();
            if (got.status !== want.status || got.run_start !== want.run_start ||
                got.run_width !== want.run_width || got.run_dark !== want.run_dark ||
                got.run_count !== want.run_count || got.mean_width !== want.mean_width ||
                got.take_length !== want.take_length || got.last !== want.last)
                note_failure({"run word mismatch: expected ", describe(want),
                              " got ", describe(got)});
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    run_tracker tracker;
    logic [LUMA_W-1:0] take_levels [$];
    int steady_left = 0;

    barcode_take_segmenter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_run(m_data);
            if (cfg_valid && cfg_ready)
                tracker.set_register(cfg_reg_t'(cfg_index), int'(cfg_data));
            if (s_valid && s_ready)
                tracker.record_frame(s_data);
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            steady_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic in_word_t frame_of(logic [LUMA_W-1:0] level, bit last_frame);
        in_word_t w;
        int total;
        int red;
        int green;
        int rest;
        total = int'(level) * 768 + int'($urandom_range(767));
        if (total > 196605)
            total = 196605;
        red = $urandom_range(total < 65535 ? total : 65535, total > 131070 ? total - 131070 : 0);
        rest = total - red;
        green = $urandom_range(rest < 65535 ? rest : 65535, rest > 65535 ? rest - 65535 : 0);
        w.red_level = LEVEL_W'(red);
        w.green_level = LEVEL_W'(green);
        w.blue_level = LEVEL_W'(rest - green);
        w.end_of_take = last_frame;
        return w;
    endfunction

    task automatic send_frame(in_word_t w);
        int gap;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_take();
        for (int i = 0; i < take_levels.size(); i++)
            send_frame(frame_of(take_levels[i], i == take_levels.size() - 1));
    endtask

    task automatic fill_pattern(int len, int dark, int light, int bar_min, int bar_max,
                                int jitter, int glitch_pct);
        bit dark_bar;
        int left;
        int v;
        take_levels.delete();
        dark_bar = $urandom_range(1);
        left = $urandom_range(bar_max, bar_min);
        for (int i = 0; i < len; i++) begin
            v = (dark_bar ? dark : light) + int'($urandom_range(2 * jitter)) - jitter;
            if ($urandom_range(99) < glitch_pct)
                v = $urandom_range(255);
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            take_levels.push_back(LUMA_W'(v));
            left--;
            if (left == 0) begin
                dark_bar = !dark_bar;
                left = $urandom_range(bar_max, bar_min);
            end
        end
    endtask

    task automatic wait_for_runs(int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_runs.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_register(cfg_reg_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            int r;
            int ready_len;
            int stall_len;
            r = $urandom_range(99);
            if (r < 10) begin
                ready_len = $urandom_range(300, 100);
                stall_len = $urandom_range(2, 1);
            end else if (r < 20) begin
                ready_len = $urandom_range(3, 1);
                stall_len = $urandom_range(40, 10);
            end else begin
                ready_len = $urandom_range(6, 1);
                stall_len = $urandom_range(3, 1);
            end
            m_ready <= 1'b1;
            repeat (ready_len) @(posedge aclk);
            m_ready <= 1'b0;
            repeat (stall_len) @(posedge aclk);
        end
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        in_word_t w;
        int random_frames;
        int phase;
        int takes;
        int kind;
        int len;
        int dark;
        int min_take;
        int r;
        tracker = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MIN_TAKE;
        cfg_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes of every level, too short under the reset settings
        send_frame('{16'h0000, 16'h0000, 16'h0000, 1'b0});
        send_frame('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0});
        send_frame('{16'hFFFF, 16'h0000, 16'hFFFF, 1'b1});
        wait_for_runs(32);
        write_register(REG_MIN_TAKE, 0);
        write_register(REG_MIN_ELEM, 1);
        take_levels = {8'd77};
        send_take();
        take_levels = {8'd100, 8'd140};
        send_take();
        take_levels = {8'd10, 8'd25, 8'd10};
        send_take();
        take_levels = {8'd10, 8'd26, 8'd10};
        send_take();
        take_levels = {8'd0, 8'd200, 8'd110, 8'd120, 8'd90, 8'd100, 8'd200, 8'd0};
        send_take();
        fill_pattern(80, 0, 255, 1, 1, 0, 0);
        send_take();
        wait_for_runs(32);
        write_register(REG_MIN_ELEM, 0);
        take_levels = {8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
        send_take();
        wait_for_runs(32);
        write_register(REG_MIN_ELEM, 4096);
        take_levels = {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        send_take();
        wait_for_runs(32);
        write_register(REG_MIN_ELEM, 3);
        take_levels = {8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255,
                       8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
        send_take();
        wait_for_runs(32);
        write_register(REG_MIN_TAKE, 4096);
        write_register(REG_MIN_ELEM, 2);
        fill_pattern(10, 20, 220, 2, 3, 0, 0);
        send_take();

        random_frames = 0;
        phase = 0;
        while (random_frames < 170) begin
            wait_for_runs(32);
            r = $urandom_range(99);
            min_take = r < 70 ? $urandom_range(24, 4) : r < 85 ? 0 :
                       r < 95 ? $urandom_range(64, 25) : 4096;
            write_register(REG_MIN_TAKE, min_take);
            r = $urandom_range(99);
            write_register(REG_MIN_ELEM, r < 70 ? $urandom_range(4, 1) : r < 85 ? 1 :
                                         r < 95 ? $urandom_range(12, 5) : 4096);
            takes = $urandom_range(6, 3);
            for (int t = 0; t < takes; t++) begin
                kind = $urandom_range(99);
                len = $urandom_range(99) < 85 ? $urandom_range(40, 8) : $urandom_range(90, 41);
                if (len < min_take && min_take < 100)
                    len = min_take + $urandom_range(8);
                dark = $urandom_range(100);
                if (kind < 70) begin
                    fill_pattern(len, dark, $urandom_range(255, dark + 16), 1, 6,
                                 $urandom_range(8), 5);
                    send_take();
                end else if (kind < 80) begin
                    fill_pattern(len, dark, dark + $urandom_range(12), 1, 6, 1, 0);
                    send_take();
                end else if (kind < 90) begin
                    len = min_take > 1 ? $urandom_range(min_take - 1 < 40 ? min_take - 1 : 40, 1)
                                       : 1;
                    fill_pattern(len, dark, $urandom_range(255, dark + 16), 1, 4, 3, 0);
                    send_take();
                end else begin
                    for (int i = 0; i < len; i++) begin
                        w.red_level = LEVEL_W'($urandom);
                        w.green_level = LEVEL_W'($urandom);
                        w.blue_level = LEVEL_W'($urandom);
                        w.end_of_take = i == len - 1;
                        send_frame(w);
                    end
                end
                random_frames += len;
                // hold the sender until every run word has come back
                if (phase == 1 && t == 1)
                    wait_for_runs(0);
            end
            phase++;
        end

        wait_for_runs(64);
        if (tracker.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/bts_pkg.sv
rtl/bts_front.sv
rtl/bts_queue.sv
rtl/bts_divider.sv
rtl/bts_back.sv
rtl/barcode_take_segmenter.sv
tb/barcode_take_segmenter_test.sv
